FILE: sv/rcm_pkg.sv
// ---------------------------------------------------------------------------
// rcm_pkg
// shared types and constants of the mutual exclusion node
// ---------------------------------------------------------------------------
package rcm_pkg;

  localparam int MAX_NODES_DEF = 8;
  localparam int TIME_W        = 32;
  localparam int RANK_W        = 3;
  localparam int COUNT_W       = 4;
  localparam int KIND_W        = 2;
  localparam int QDEPTH        = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_OWN_RANK   = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  localparam logic [KIND_W-1:0] MSG_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] MSG_REQ   = 2'd1;
  localparam logic [KIND_W-1:0] MSG_REPLY = 2'd2;

  typedef enum logic [1:0] {
    EV_RX_REQ    = 2'd0,
    EV_RX_REPLY  = 2'd1,
    EV_LOC_REQ   = 2'd2,
    EV_LOC_REL   = 2'd3
  } ev_t;

  typedef struct packed {
    ev_t               ev;
    logic [RANK_W-1:0] peer;
    logic [TIME_W-1:0] msg_time;
    logic              first;
  } qitem_t;

  typedef struct packed {
    logic [RANK_W-1:0]  own_rank;
    logic [COUNT_W-1:0] node_count;
    logic               rank_wr;
  } cfg_t;

endpackage

FILE: sv/rcm_front.sv
// ---------------------------------------------------------------------------
// rcm_front
// accepts events, classifies them and holds them in a short queue
// ---------------------------------------------------------------------------
module rcm_front
  import rcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [RANK_W-1:0] in_peer,
  input  logic [TIME_W-1:0] in_msg_time,
  input  logic              in_first_request,
  output logic              q_valid,
  output qitem_t            q_item,
  input  logic              q_pop
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qitem_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;
  qitem_t             item_in;

  assign full    = (cnt_r == CNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rptr_r];
  assign do_wr   = push && !full;
  assign do_rd   = q_pop && q_valid;

  always_comb begin
    item_in.ev       = ev_t'(in_req_type);
    item_in.peer     = in_peer;
    item_in.msg_time = in_msg_time;
    item_in.first    = in_first_request;
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= item_in;
    end
  end

endmodule

FILE: sv/rcm_back.sv
// ---------------------------------------------------------------------------
// rcm_back
// protocol engine: node state, message sequencer and result register
// ---------------------------------------------------------------------------
module rcm_back
  import rcm_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_valid,
  input  qitem_t            q_item,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [KIND_W-1:0] out_msg_kind,
  output logic [RANK_W-1:0] out_dest,
  output logic [TIME_W-1:0] out_time,
  output logic              out_granted,
  output logic              out_last
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REPLY  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_STATUS = 4'b1000
  } st_t;

  st_t                   st_r, st_nxt;
  logic [TIME_W-1:0]     clock_r, clock_nxt;
  logic [TIME_W-1:0]     rtime_r, rtime_nxt;
  logic                  in_sec_r, in_sec_nxt;
  logic                  reqing_r, reqing_nxt;
  logic [MAX_NODES-1:0]  def_r, def_nxt;
  logic [MAX_NODES-1:0]  await_r, await_nxt;
  logic [MAX_NODES-1:0]  repl_r, repl_nxt;
  logic [MAX_NODES-1:0]  todo_r, todo_nxt;
  logic                  scan_req_r, scan_req_nxt;
  logic [RANK_W-1:0]     rpeer_r, rpeer_nxt;

  logic                  ov_r, ov_nxt;
  logic [KIND_W-1:0]     okind_r, okind_nxt;
  logic [RANK_W-1:0]     odest_r, odest_nxt;
  logic [TIME_W-1:0]     otime_r, otime_nxt;
  logic                  ogrant_r, ogrant_nxt;
  logic                  olast_r, olast_nxt;

  logic                  out_free;
  logic [MAX_NODES-1:0]  act_mask, rank_mask, pb_in, pb_rp, low_bit, tgt, aw;
  logic [IDX_W-1:0]      low_idx;
  logic [TIME_W-1:0]     clk_rx, clk_inc;
  logic                  defer, prio_peer;

  assign out_free     = !ov_r || pop;
  assign q_pop        = (st_r == ST_IDLE) && q_valid;
  assign empty        = !ov_r;
  assign out_msg_kind = okind_r;
  assign out_dest     = odest_r;
  assign out_time     = otime_r;
  assign out_granted  = ogrant_r;
  assign out_last     = olast_r;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      act_mask[i]  = (i < int'(cfg.node_count));
      rank_mask[i] = (i < int'(cfg.own_rank));
    end
    low_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (todo_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign pb_in   = {{(MAX_NODES-1){1'b0}}, 1'b1} << q_item.peer;
  assign pb_rp   = {{(MAX_NODES-1){1'b0}}, 1'b1} << rpeer_r;
  assign low_bit = todo_r & (~todo_r + 1'b1);
  assign clk_inc = clock_r + 1'b1;
  assign clk_rx  = ((clock_r > q_item.msg_time) ? clock_r : q_item.msg_time) + 1'b1;

  // peer wins over our own pending request
  assign prio_peer = (q_item.msg_time < rtime_r) ||
                     ((q_item.msg_time == rtime_r) && (cfg.own_rank > q_item.peer));
  assign defer     = in_sec_r || (reqing_r && !prio_peer);
  assign aw        = await_r & ~pb_in;
  assign tgt       = (repl_r | ((q_item.first && (cfg.own_rank != '0)) ? await_r : '0))
                     & act_mask;

  always_comb begin
    st_nxt       = st_r;
    clock_nxt    = clock_r;
    rtime_nxt    = rtime_r;
    in_sec_nxt   = in_sec_r;
    reqing_nxt   = reqing_r;
    def_nxt      = def_r;
    await_nxt    = await_r;
    repl_nxt     = repl_r;
    todo_nxt     = todo_r;
    scan_req_nxt = scan_req_r;
    rpeer_nxt    = rpeer_r;
    ov_nxt       = ov_r && !pop;
    okind_nxt    = okind_r;
    odest_nxt    = odest_r;
    otime_nxt    = otime_r;
    ogrant_nxt   = ogrant_r;
    olast_nxt    = olast_r;

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          st_nxt = ST_STATUS;
          case (q_item.ev)
            EV_RX_REQ: begin
              clock_nxt = clk_rx;
              if (defer) begin
                def_nxt = def_r | pb_in;
              end else begin
                rpeer_nxt = q_item.peer;
                st_nxt    = ST_REPLY;
              end
            end
            EV_RX_REPLY: begin
              clock_nxt = clk_rx;
              await_nxt = aw;
              repl_nxt  = repl_r & ~pb_in;
              if (reqing_r && (aw == '0)) begin
                in_sec_nxt = 1'b1;
                reqing_nxt = 1'b0;
              end
            end
            EV_LOC_REQ: begin
              if (!in_sec_r && !reqing_r) begin
                clock_nxt = clk_inc;
                rtime_nxt = clk_inc;
                if (tgt == '0) begin
                  in_sec_nxt = 1'b1;
                end else begin
                  reqing_nxt   = 1'b1;
                  await_nxt    = await_r | tgt;
                  todo_nxt     = tgt;
                  scan_req_nxt = 1'b1;
                  st_nxt       = ST_SCAN;
                end
              end
            end
            EV_LOC_REL: begin
              in_sec_nxt   = 1'b0;
              def_nxt      = '0;
              todo_nxt     = def_r & act_mask;
              scan_req_nxt = 1'b0;
              if ((def_r & act_mask) != '0) begin
                st_nxt = ST_SCAN;
              end
            end
            default: begin
              st_nxt = ST_STATUS;
            end
          endcase
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          clock_nxt  = clk_inc;
          repl_nxt   = repl_r | pb_rp;
          ov_nxt     = 1'b1;
          okind_nxt  = MSG_REPLY;
          odest_nxt  = rpeer_r;
          otime_nxt  = clk_inc;
          ogrant_nxt = in_sec_r;
          olast_nxt  = 1'b0;
          st_nxt     = ST_STATUS;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          odest_nxt  = RANK_W'(low_idx);
          ogrant_nxt = in_sec_r;
          olast_nxt  = 1'b0;
          if (scan_req_r) begin
            okind_nxt = MSG_REQ;
            otime_nxt = rtime_r;
          end else begin
            okind_nxt = MSG_REPLY;
            otime_nxt = clk_inc;
            clock_nxt = clk_inc;
            repl_nxt  = repl_r | low_bit;
          end
          todo_nxt = todo_r & ~low_bit;
          if ((todo_r & ~low_bit) == '0) begin
            st_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = MSG_NONE;
          odest_nxt  = '0;
          otime_nxt  = clock_r;
          ogrant_nxt = in_sec_r;
          olast_nxt  = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (cfg.rank_wr) begin
      await_nxt = rank_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      clock_r    <= '0;
      rtime_r    <= '0;
      in_sec_r   <= 1'b0;
      reqing_r   <= 1'b0;
      def_r      <= '0;
      await_r    <= '0;
      repl_r     <= '0;
      todo_r     <= '0;
      scan_req_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clock_r    <= clock_nxt;
      rtime_r    <= rtime_nxt;
      in_sec_r   <= in_sec_nxt;
      reqing_r   <= reqing_nxt;
      def_r      <= def_nxt;
      await_r    <= await_nxt;
      repl_r     <= repl_nxt;
      todo_r     <= todo_nxt;
      scan_req_r <= scan_req_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpeer_r  <= rpeer_nxt;
    okind_r  <= okind_nxt;
    odest_r  <= odest_nxt;
    otime_r  <= otime_nxt;
    ogrant_r <= ogrant_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

FILE: sv/rc_mutex_node.sv
// ---------------------------------------------------------------------------
// rc_mutex_node
// one node of roucairol-carvalho mutual exclusion with a lamport clock
// ---------------------------------------------------------------------------
// Events enter through a two-deep queue and are carried out one at a time by
// the protocol engine. An event is first decoded and then produces its results
// in order: every message (one per target rank, found lowest rank first by a
// priority encoder) and then the closing status result. The single result
// register takes one result per cycle while pop keeps up, and it holds the
// engine while it is full and not popped. Configuration is written over the
// apb port at byte 0 (own_rank) and byte 4 (node_count); the user must write
// it only while the node is idle, as the block itself does not enforce this.
module rc_mutex_node
  import rcm_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_req_type,
  input  logic [RANK_W-1:0]     in_peer,
  input  logic [TIME_W-1:0]     in_msg_time,
  input  logic                  in_first_request,
  output logic                  empty,
  input  logic                  pop,
  output logic [KIND_W-1:0]     out_msg_kind,
  output logic [RANK_W-1:0]     out_dest,
  output logic [TIME_W-1:0]     out_time,
  output logic                  out_granted,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RANK_W-1:0]  own_rank_r, own_rank_nxt;
  logic [COUNT_W-1:0] node_count_r, node_count_nxt;
  logic               wr_en;
  cfg_t               cfg;
  logic               q_valid, q_pop;
  qitem_t             q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    own_rank_nxt   = own_rank_r;
    node_count_nxt = node_count_r;
    if (wr_en) begin
      if (paddr[2] == REG_OWN_RANK) begin
        own_rank_nxt = pwdata[RANK_W-1:0];
      end else begin
        node_count_nxt = pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_NODE_COUNT) begin
      prdata = CFG_DATA_W'(node_count_r);
    end else begin
      prdata = CFG_DATA_W'(own_rank_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r   <= '0;
      node_count_r <= COUNT_W'(8);
    end else begin
      own_rank_r   <= own_rank_nxt;
      node_count_r <= node_count_nxt;
    end
  end

  always_comb begin
    cfg.own_rank   = own_rank_r;
    cfg.node_count = node_count_r;
    cfg.rank_wr    = wr_en && (paddr[2] == REG_OWN_RANK);
  end

  // rank reload of the awaiting set uses the new rank value
  logic [RANK_W-1:0] rank_for_reload;
  assign rank_for_reload = own_rank_nxt;

  cfg_t cfg_back;
  always_comb begin
    cfg_back          = cfg;
    if (cfg.rank_wr) begin
      cfg_back.own_rank = rank_for_reload;
    end
  end

  rcm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_peer          (in_peer),
    .in_msg_time      (in_msg_time),
    .in_first_request (in_first_request),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  rcm_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_back),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_msg_kind (out_msg_kind),
    .out_dest     (out_dest),
    .out_time     (out_time),
    .out_granted  (out_granted),
    .out_last     (out_last)
  );

endmodule
